// ===== src/hsc_pkg.sv =====
// Shared types, constants and position helpers for the Hamming SEC codec.
// Used by hsc_core and hamming_sec_codec; depends on nothing else.
package hsc_pkg;

  localparam int MAX_CODE_BITS = 64;
  localparam int WORD_W        = 64;
  localparam int CNT_W         = $clog2(MAX_CODE_BITS + 1);
  localparam int SYN_W         = 7;
  localparam int PAR_MAX       = CNT_W;
  localparam int DATA_MAX      = MAX_CODE_BITS - PAR_MAX;
  localparam int DBITS_W       = 6;
  localparam int PBITS_W       = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 6;
  localparam int OUT_TDATA_W   = 80;

  localparam logic [DBITS_W-1:0] DATA_BITS_RST   = 6'd4;
  localparam logic [PBITS_W-1:0] PARITY_BITS_RST = 3'd3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_BITS = 1'b1;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic              syndrome_out_of_range;
    logic [SYN_W-1:0]  syndrome;
    logic              error_found;
    logic [WORD_W-1:0] out_word;
  } hsc_result_t;

  function automatic bit is_pow2(input int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // 1-based codeword position that carries data bit k
  function automatic int data_pos(input int k);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 1; p <= MAX_CODE_BITS; p++) begin
      if (!is_pow2(p)) begin
        if (cnt == k) pos = p;
        cnt++;
      end
    end
    return pos;
  endfunction

  // positions covered by parity bit j: bit i set when (i+1) has bit j set
  function automatic logic [WORD_W-1:0] cover_mask(input int j);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = ((((i + 1) >> j) & 1) != 0);
    end
    return m;
  endfunction

endpackage

// ===== src/hsc_core.sv =====
// Combinational Hamming encode / decode for one word.
// Depends on hsc_pkg for widths, position helpers and the result struct.
module hsc_core
  import hsc_pkg::*;
(
  input  req_type_e         req_i,
  input  logic [WORD_W-1:0] word_i,
  input  logic [CNT_W-1:0]  code_len_i,
  output hsc_result_t       res_o
);

  logic [WORD_W-1:0]   len_mask;
  logic [WORD_W-1:0]   spread;
  logic [WORD_W-1:0]   enc_data;
  logic [WORD_W-1:0]   par_vec;
  logic [WORD_W-1:0]   codeword;
  logic [PAR_MAX-1:0]  par_x;
  logic [WORD_W-1:0]   rx_word;
  logic [SYN_W-1:0]    syn;
  logic                syn_nz;
  logic                syn_in_range;
  logic [CNT_W-2:0]    flip_idx;
  logic [WORD_W-1:0]   corr;
  logic [DATA_MAX-1:0] gather;

  for (genvar i = 0; i < WORD_W; i++) begin : g_mask
    assign len_mask[i] = (CNT_W'(i) < code_len_i);
  end

  // scatter data bits into non-power-of-two positions, gather them back
  for (genvar k = 0; k < DATA_MAX; k++) begin : g_map
    localparam int Pos = data_pos(k);
    assign spread[Pos-1] = word_i[k];
    assign gather[k]     = corr[Pos-1];
  end
  for (genvar j = 0; j < PAR_MAX; j++) begin : g_ppos
    assign spread[(1 << j) - 1] = 1'b0;
  end

  assign enc_data = spread & len_mask;
  assign rx_word  = word_i & len_mask;

  for (genvar j = 0; j < PAR_MAX; j++) begin : g_par
    localparam logic [WORD_W-1:0] Cover = cover_mask(j);
    assign par_x[j] = ^(enc_data & Cover);
    assign syn[j]   = ^(rx_word & Cover);
  end

  always_comb begin
    par_vec = '0;
    for (int j = 0; j < PAR_MAX; j++) begin
      par_vec[(1 << j) - 1] = par_x[j];
    end
  end

  assign codeword = (enc_data | par_vec) & len_mask;

  assign syn_nz       = (syn != '0);
  assign syn_in_range = (syn <= code_len_i);
  assign flip_idx     = (CNT_W - 1)'(syn - SYN_W'(1));
  assign corr = (syn_nz && syn_in_range)
              ? (rx_word ^ (WORD_W'(1) << flip_idx)) : rx_word;

  always_comb begin
    res_o = '0;
    case (req_i)
      REQ_ENCODE: begin
        res_o.out_word = codeword;
      end
      default: begin
        res_o.out_word              = WORD_W'(gather);
        res_o.error_found           = syn_nz;
        res_o.syndrome              = syn;
        res_o.syndrome_out_of_range = syn_nz && !syn_in_range;
      end
    endcase
  end

endmodule

// ===== src/hamming_sec_codec.sv =====
// Hamming single-error-correcting codec, top level with stream ports.
// Depends on hsc_pkg and hsc_core.
//
// Usage:
//   Slave stream carries one request per beat: tuser selects encode (0) or
//   decode (1), tdata holds the data word or the codeword (bit i = position
//   i+1). Master stream returns one result per request, in order.
//   Configure data_bits and parity_bits through the write port while idle;
//   the code length is their sum, capped at 64 positions.
//   A request passes through the input register, then the result register,
//   with the parity trees and correction logic between them.
//   Throughput: one request per cycle, sustained, while the sink takes
//   results each cycle. A bubble in either register lets the source keep
//   sending while a finished result waits.
//   When the sink stalls, the result register holds; tready falls once both
//   registers are full and rises again as soon as the sink takes a result.
//   Reset: both stages empty, data_bits = 4, parity_bits = 3.
module hamming_sec_codec
  import hsc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave request stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [WORD_W-1:0]      s_axis_tdata_i,  // [63:0] in_word
  input  logic                   s_axis_tuser_i,  // [0] req_type
  // master result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [63:0] out_word, [64] error_found, [71:65] syndrome,
  // [72] syndrome_out_of_range, [79:73] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int ResW = $bits(hsc_result_t);

  logic [DBITS_W-1:0] data_bits_q;
  logic [PBITS_W-1:0] parity_bits_q;
  logic [CNT_W-1:0]   len_sum;
  logic [CNT_W-1:0]   code_len;

  logic               in_valid_q;
  req_type_e          in_req_q;
  logic [WORD_W-1:0]  in_word_q;
  logic               out_valid_q;
  hsc_result_t        out_res_q;
  hsc_result_t        res_d;

  logic               out_adv;
  logic               in_adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q   <= DATA_BITS_RST;
      parity_bits_q <= PARITY_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DATA_BITS:   data_bits_q   <= cfg_wdata_i[DBITS_W-1:0];
        CFG_PARITY_BITS: parity_bits_q <= cfg_wdata_i[PBITS_W-1:0];
        default: ;
      endcase
    end
  end

  // code length, capped at the widest codeword
  assign len_sum  = CNT_W'(data_bits_q) + CNT_W'(parity_bits_q);
  assign code_len = (len_sum > CNT_W'(MAX_CODE_BITS)) ? CNT_W'(MAX_CODE_BITS) : len_sum;

  // advance a stage when its downstream slot is free or emptying
  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign in_adv          = !in_valid_q || out_adv;
  assign s_axis_tready_o = in_adv;

  // input register: hold the request until the result stage can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid_i) begin
      in_req_q  <= req_type_e'(s_axis_tuser_i);
      in_word_q <= s_axis_tdata_i;
    end
  end

  hsc_core u_core (
    .req_i      (in_req_q),
    .word_i     (in_word_q),
    .code_len_i (code_len),
    .res_o      (res_d)
  );

  // result register: hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - ResW)'(0), out_res_q};

  // a request in the input stage always moves on when the result slot frees
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_adv) |=> out_valid_q)
    else $error("request lost between input and result stage");

  // out-of-range syndrome is always a detected error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.syndrome_out_of_range) |-> out_res_q.error_found)
    else $error("out-of-range syndrome without error flag");

  // error flag and syndrome agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.error_found == (out_res_q.syndrome != '0)))
    else $error("error flag disagrees with syndrome");

  // an encode request leaves the error flag and syndrome clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_adv && (in_req_q == REQ_ENCODE)) |=>
      (!out_res_q.error_found && (out_res_q.syndrome == '0)))
    else $error("encode result carries decode flags");

endmodule

// ===== verif/tb_hamming_sec_codec.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for hamming_sec_codec: encode and decode requests are
// checked against an in-bench Hamming model across many code lengths.
// Depends on hsc_pkg and the hamming_sec_codec RTL.
module tb_hamming_sec_codec;
  import hsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;   // quiet cycles before a register write
  localparam int TAIL_QUIET     = 250; // final requests run without idling
  localparam int PHASE_REQS     = 120;
  localparam int NUM_PHASES     = 16;

  typedef enum logic [1:0] {
    STEP_REQ,
    STEP_CFG,
    STEP_DRAIN
  } step_kind_e;

  typedef struct packed {
    step_kind_e             kind;
    req_type_e              req;
    logic [WORD_W-1:0]      word;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_val;
  } stim_step_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [WORD_W-1:0]      s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = REQ_ENCODE;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = CFG_DATA_BITS;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  hamming_sec_codec uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Hamming model: positions are 1-based, parity at powers of two up to n.
  // ---------------------------------------------------------------------------
  function automatic int code_length(logic [DBITS_W-1:0] db, logic [PBITS_W-1:0] pb);
    int n;
    n = int'(db) + int'(pb);
    return (n > MAX_CODE_BITS) ? MAX_CODE_BITS : n;
  endfunction

  function automatic logic [WORD_W-1:0] hamming_encode(logic [WORD_W-1:0] data, int n);
    logic [WORD_W-1:0] cw;
    int k;
    int x;
    cw = '0;
    k  = 0;
    x  = 0;
    // scatter data bits into the non-parity positions, lowest first
    for (int p = 1; p <= n; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (data[k]) begin
          cw[p-1] = 1'b1;
          x ^= p;
        end
        k++;
      end
    end
    // each parity bit cancels its share of the position XOR
    for (int p = 1; p <= n; p = p * 2) begin
      if ((x & p) != 0) cw[p-1] = 1'b1;
    end
    return cw;
  endfunction

  function automatic hsc_result_t predict_result(req_type_e kind, logic [WORD_W-1:0] word,
                                                 int n);
    hsc_result_t res;
    int s;
    int k;
    res = '0;
    if (kind == REQ_ENCODE) begin
      res.out_word = hamming_encode(word, n);
      return res;
    end
    s = 0;
    for (int p = 1; p <= n; p++) begin
      if (word[p-1]) s ^= p;
    end
    if (s != 0) begin
      res.error_found = 1'b1;
      // a syndrome pointing past the codeword cannot be corrected
      if (s <= n) word[s-1] = ~word[s-1];
      else res.syndrome_out_of_range = 1'b1;
    end
    k = 0;
    for (int p = 1; p <= n; p++) begin
      if ((p & (p - 1)) != 0) begin
        res.out_word[k] = word[p-1];
        k++;
      end
    end
    res.syndrome = s[SYN_W-1:0];
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  stim_step_t  stim_q[$];      // pending requests, register writes and drain points
  hsc_result_t expected_q[$];  // predicted results, oldest first

  logic [DBITS_W-1:0] cur_data_bits   = DATA_BITS_RST;
  logic [PBITS_W-1:0] cur_parity_bits = PARITY_BITS_RST;

  int  total_reqs     = 0;
  int  accepted_reqs  = 0;
  int  checked_results = 0;
  int  encode_cnt     = 0;
  int  decode_cnt     = 0;
  int  corrected_cnt  = 0;
  int  out_of_range_cnt = 0;
  int  cfg_write_cnt  = 0;
  int  drain_cnt      = 0;
  int  mismatch_cnt   = 0;
  int  idle_level     = 1;   // 0 none, 1 light, 2 heavy bursts on both sides
  int  settle_cnt     = 0;
  int  quiet_cycles   = 0;
  bit  req_taken      = 1'b0;
  int  send_gap       = 0;
  int  stall_left     = 0;

  // ---------------------------------------------------------------------------
  // Request driver: present pending steps at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_requests
    stim_step_t head;
    logic       nxt_valid;
    logic       nxt_we;
    nxt_valid = s_axis_tvalid_i;
    nxt_we    = 1'b0;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (s_axis_tvalid_i && !req_taken) begin
      // hold the request until the block takes it
    end else begin
      nxt_valid = 1'b0;
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.kind)
          STEP_REQ: begin
            if (idle_level != 0 &&
                $urandom_range(0, (idle_level == 2) ? 2 : 9) == 0) begin
              send_gap = $urandom_range(0, 13);
            end else begin
              s_axis_tdata_i <= head.word;
              s_axis_tuser_i <= head.req;
              nxt_valid = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          STEP_CFG: begin
            // write registers only once the pipeline has fully drained
            if (expected_q.size() == 0 && settle_cnt >= SETTLE_CYCLES) begin
              cfg_index_i <= head.cfg_idx;
              cfg_wdata_i <= head.cfg_val;
              nxt_we = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          default: begin
            // pressure point: stop sending until every result is back
            if (expected_q.size() == 0) begin
              drain_cnt++;
              void'(stim_q.pop_front());
            end
          end
        endcase
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    cfg_we_i        <= nxt_we;
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts on tready
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_sink
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_level != 0 &&
                 $urandom_range(0, (idle_level == 2) ? 3 : 11) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    m_axis_tready_i <= rst_ni && (stall_left == 0);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted requests, check accepted results
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    hsc_result_t exp_res;
    hsc_result_t got_res;
    logic [OUT_TDATA_W-1:WORD_W+SYN_W+2] got_pad;
    bit fired;
    if (rst_ni) begin
      fired = 1'b0;

      // check results first: a request taken at this edge cannot be answered yet
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        fired   = 1'b1;
        got_res = hsc_result_t'(m_axis_tdata_o[WORD_W+SYN_W+1:0]);
        got_pad = m_axis_tdata_o[OUT_TDATA_W-1:WORD_W+SYN_W+2];
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] unexpected result: tdata=%h", $realtime, m_axis_tdata_o);
        end else begin
          exp_res = expected_q.pop_front();
          checked_results++;
          if (got_res.out_word != exp_res.out_word ||
              got_res.error_found != exp_res.error_found ||
              got_res.syndrome != exp_res.syndrome ||
              got_res.syndrome_out_of_range != exp_res.syndrome_out_of_range ||
              got_pad != '0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $write("[%0t] result %0d mismatch: exp word=%h err=%0d syn=%0d oor=%0d",
                     $realtime, checked_results,
                     exp_res.out_word, exp_res.error_found, exp_res.syndrome,
                     exp_res.syndrome_out_of_range);
              $display(" | got word=%h err=%0d syn=%0d oor=%0d pad=%h",
                       got_res.out_word, got_res.error_found, got_res.syndrome,
                       got_res.syndrome_out_of_range, got_pad);
            end
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_o) begin
        fired     = 1'b1;
        req_taken = 1'b1;
        exp_res   = predict_result(req_type_e'(s_axis_tuser_i), s_axis_tdata_i,
                                   code_length(cur_data_bits, cur_parity_bits));
        expected_q.insert(expected_q.size(), exp_res);
        accepted_reqs++;
        if (s_axis_tuser_i == REQ_DECODE) begin
          decode_cnt++;
          if (exp_res.syndrome_out_of_range) out_of_range_cnt++;
          else if (exp_res.error_found) corrected_cnt++;
        end else begin
          encode_cnt++;
        end
        // change idling pattern now and then, drop it for the tail of the run
        if (accepted_reqs + TAIL_QUIET >= total_reqs) idle_level = 0;
        else if (accepted_reqs % 150 == 0) idle_level = $urandom_range(0, 2);
      end

      if (cfg_we_i) begin
        cfg_write_cnt++;
        if (cfg_index_i == CFG_DATA_BITS) cur_data_bits = cfg_wdata_i[DBITS_W-1:0];
        else if (cfg_index_i == CFG_PARITY_BITS) cur_parity_bits = cfg_wdata_i[PBITS_W-1:0];
      end

      if (expected_q.size() == 0 && !s_axis_tvalid_i) settle_cnt++;
      else settle_cnt = 0;

      if (fired) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog: give up when nothing moves for too long
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  int gen_n = 7;

  task automatic push_req(req_type_e kind, logic [WORD_W-1:0] word);
    stim_step_t st;
    st         = '0;
    st.kind    = STEP_REQ;
    st.req     = kind;
    st.word    = word;
    stim_q.insert(stim_q.size(), st);
    total_reqs++;
  endtask

  task automatic push_cfg(int db, int pb);
    stim_step_t st;
    st         = '0;
    st.kind    = STEP_CFG;
    st.cfg_idx = CFG_DATA_BITS;
    st.cfg_val = CFG_DATA_W'(db);
    stim_q.insert(stim_q.size(), st);
    st.cfg_idx = CFG_PARITY_BITS;
    st.cfg_val = CFG_DATA_W'(pb);
    stim_q.insert(stim_q.size(), st);
    gen_n = code_length(DBITS_W'(db), PBITS_W'(pb));
  endtask

  task automatic push_drain();
    stim_step_t st;
    st      = '0;
    st.kind = STEP_DRAIN;
    stim_q.insert(stim_q.size(), st);
  endtask

  initial begin : stimulus
    logic [WORD_W-1:0] cw;
    logic [WORD_W-1:0] above;
    int db;
    int pb;
    int pick;

    // directed: reset setting, 4 data + 3 parity, n = 7
    push_req(REQ_ENCODE, '0);
    push_req(REQ_ENCODE, '1);
    push_req(REQ_DECODE, '0);
    cw = hamming_encode(64'hA, 7);
    push_req(REQ_DECODE, cw);
    for (int i = 0; i < 7; i++) push_req(REQ_DECODE, cw ^ (64'd1 << i));
    // garbage above the codeword must be ignored
    push_req(REQ_DECODE, cw | 64'hFFFF_FFFF_FFFF_FF80);
    // n = 6: ones at positions 3 and 4 give syndrome 7, past the end
    push_cfg(3, 3);
    push_req(REQ_DECODE, 64'h0C);
    // empty codeword
    push_cfg(0, 0);
    push_req(REQ_ENCODE, '1);
    push_req(REQ_DECODE, '1);
    // full 64-position code; all ones decodes with syndrome 64
    push_cfg(57, 7);
    push_req(REQ_ENCODE, '1);
    push_req(REQ_DECODE, hamming_encode('1, 64) ^ (64'd1 << 63));
    push_req(REQ_DECODE, '1);
    // length clamped to 64, surplus data ignored
    push_cfg(63, 7);
    push_req(REQ_ENCODE, '1);
    // parity count says everything, positions still take data
    push_cfg(0, 7);
    push_req(REQ_ENCODE, '1);
    // n = 2: only parity positions, syndrome 3 is out of range
    push_cfg(1, 1);
    push_req(REQ_DECODE, 64'h3);
    push_drain();

    // random phases: fixed corner settings first, then random ones
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin db = 4;  pb = 3; end
        1:       begin db = 57; pb = 7; end
        2:       begin db = 1;  pb = 2; end
        3:       begin db = 11; pb = 4; end
        4:       begin db = 26; pb = 5; end
        5:       begin db = 63; pb = 7; end
        6:       begin db = 60; pb = 0; end
        7:       begin db = 0;  pb = 7; end
        8:       begin db = 1;  pb = 1; end
        9:       begin db = 5;  pb = 2; end
        default: begin db = $urandom_range(0, 63); pb = $urandom_range(0, 7); end
      endcase
      push_cfg(db, pb);
      above = (gen_n >= WORD_W) ? '0 : ~((64'd1 << gen_n) - 64'd1);
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (i == PHASE_REQS / 2 && (ph % 4) == 1) push_drain();
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          push_req(REQ_ENCODE, rand_word());
        end else if (pick < 9) begin
          // well-formed codeword, at most one flipped bit, sometimes junk above n
          cw = hamming_encode(rand_word(), gen_n);
          if (gen_n > 0 && $urandom_range(0, 2) != 0)
            cw ^= 64'd1 << $urandom_range(0, gen_n - 1);
          if ($urandom_range(0, 3) == 0) cw |= rand_word() & above;
          push_req(REQ_DECODE, cw);
        end else begin
          push_req(REQ_DECODE, rand_word());
        end
      end
    end

    // release reset on a falling clock edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_q.size() != 0 || s_axis_tvalid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d requests (%0d encodes, %0d decodes: %0d corrected, %0d past the end)",
             accepted_reqs, encode_cnt, decode_cnt, corrected_cnt, out_of_range_cnt);
    $display("with %0d register writes, %0d drain pauses, %0d results checked, %0d mismatches",
             cfg_write_cnt, drain_cnt, checked_results, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
